@@ design/sips_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sips_pkg
// Shared types and constants of the SCSI initiator phase sequencer.
// ----------------------------------------------------------------------------
package sips_pkg;

  // Command descriptor block storage
  localparam int CDB_BYTES = 10;
  localparam int CDB_AW    = $clog2(CDB_BYTES);
  localparam int CPOS_W    = $clog2(CDB_BYTES + 1);

  // Result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  // Action codes
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  // Bus write port codes
  localparam logic [1:0] BW_NONE = 2'd0;
  localparam logic [1:0] BW_DATA = 2'd1;
  localparam logic [1:0] BW_CMD  = 2'd2;

  // Bus phase codes (status bits 6-4)
  localparam logic [2:0] PH_DATA_OUT = 3'b000;
  localparam logic [2:0] PH_COMMAND  = 3'b001;
  localparam logic [2:0] PH_DATA_IN  = 3'b100;
  localparam logic [2:0] PH_STATUS   = 3'b101;
  localparam logic [2:0] PH_MSG_IN   = 3'b111;

  // Bytes written to the controller
  localparam logic [7:0] SEL_OWN_ID   = 8'h80;
  localparam logic [7:0] CMD_SELECT   = 8'h86;
  localparam logic [7:0] CMD_SEQUENCE = 8'h82;

  localparam logic [15:0] WAIT_LIMIT_RST = 16'd3000;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FREE = 5'b00010,
    S_BUSY = 5'b00100,
    S_RUN  = 5'b01000,
    S_DMA  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  target_id;
    logic [31:0] buffer_address;
    logic [3:0]  cdb_index;
    logic [7:0]  cdb_byte;
    logic [7:0]  bus_status;
    logic [7:0]  bus_data;
    logic        dma_terminal;
  } item_t;

  typedef struct packed {
    logic [1:0]  bus_write;
    logic [7:0]  bus_write_value;
    logic        dma_start;
    logic        dma_to_device;
    logic [31:0] dma_address;
    logic [15:0] dma_count;
    logic        dma_stop;
    logic        done_res;
    logic        timed_out;
    logic [7:0]  target_status;
    logic [7:0]  target_message;
    logic        last;
  } res_t;

  // Results of one step toward the result queue
  typedef struct packed {
    logic push;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

endpackage
`default_nettype wire

@@ design/sips_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sips_core
// Sequencer state and the combinational step that turns one registered item
// into one or two results.
// ----------------------------------------------------------------------------
module sips_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [15:0]    cfg_wdata_i,
  input  wire logic           step_i,
  input  wire sips_pkg::item_t item_i,
  output sips_pkg::push_t     push_o
);

  sips_pkg::state_e                state_q, state_d;
  logic [15:0]                     wlim_q;
  logic [15:0]                     poll_q, poll_d;
  logic [7:0]                      cb_q [sips_pkg::CDB_BYTES];
  logic                            cb_we;
  logic [sips_pkg::CPOS_W-1:0]     pos_q, pos_d;
  logic [31:0]                     addr_q, addr_d;
  logic [2:0]                      tgt_q, tgt_d;
  logic [7:0]                      stat_q, stat_d;
  logic [7:0]                      msg_q, msg_d;
  logic                            dir_q, dir_d;

  logic                            busy;
  logic                            req;
  logic [2:0]                      phase;
  logic                            left;
  logic [16:0]                     poll_inc;
  logic                            poll_out;
  logic [31:0]                     addr_next_seg;
  logic                            pos_in;
  logic [7:0]                      cb_rd;
  sips_pkg::res_t                  r0, r1;
  logic                            two;

  assign busy          = item_i.bus_status[3];
  assign req           = item_i.bus_status[7];
  assign phase         = item_i.bus_status[6:4];
  assign left          = (item_i.bus_status[5:4] != 2'b00) || !busy;
  assign poll_inc      = {1'b0, poll_q} + 17'd1;
  assign poll_out      = poll_inc >= {1'b0, wlim_q};
  assign addr_next_seg = {addr_q[31:16] + 16'd1, 16'h0000};
  assign pos_in        = pos_q < sips_pkg::CPOS_W'(sips_pkg::CDB_BYTES);
  assign cb_rd         = pos_in ? cb_q[pos_q[sips_pkg::CDB_AW-1:0]] : 8'h00;
  assign cb_we         = step_i && (item_i.action == sips_pkg::ACT_LOAD)
                         && (32'(item_i.cdb_index) < 32'(sips_pkg::CDB_BYTES));

  // Decide results and next state for the item in the input register
  always_comb begin
    state_d = state_q;
    poll_d  = poll_q;
    pos_d   = pos_q;
    addr_d  = addr_q;
    tgt_d   = tgt_q;
    stat_d  = stat_q;
    msg_d   = msg_q;
    dir_d   = dir_q;
    r0      = '0;
    r1      = '0;
    two     = 1'b0;

    if (item_i.action == sips_pkg::ACT_START) begin
      if (state_q == sips_pkg::S_IDLE) begin
        tgt_d   = item_i.target_id;
        addr_d  = item_i.buffer_address;
        poll_d  = '0;
        pos_d   = '0;
        stat_d  = '0;
        msg_d   = '0;
        dir_d   = 1'b0;
        state_d = sips_pkg::S_FREE;
      end
    end else if (item_i.action == sips_pkg::ACT_SAMPLE) begin
      unique case (state_q)
        sips_pkg::S_IDLE: begin
        end
        sips_pkg::S_FREE: begin
          if (!busy) begin
            r0.bus_write       = sips_pkg::BW_DATA;
            r0.bus_write_value = sips_pkg::SEL_OWN_ID | (8'd1 << tgt_q);
            r1.bus_write       = sips_pkg::BW_CMD;
            r1.bus_write_value = sips_pkg::CMD_SELECT;
            two                = 1'b1;
            poll_d             = '0;
            state_d            = sips_pkg::S_BUSY;
          end else if (poll_out) begin
            r0.done_res = 1'b1;
            r0.timed_out = 1'b1;
            state_d     = sips_pkg::S_IDLE;
          end else begin
            poll_d = poll_inc[15:0];
          end
        end
        sips_pkg::S_BUSY: begin
          if (busy) begin
            r0.bus_write       = sips_pkg::BW_CMD;
            r0.bus_write_value = sips_pkg::CMD_SEQUENCE;
            state_d            = sips_pkg::S_RUN;
          end else if (poll_out) begin
            r0.done_res = 1'b1;
            r0.timed_out = 1'b1;
            state_d     = sips_pkg::S_IDLE;
          end else begin
            poll_d = poll_inc[15:0];
          end
        end
        sips_pkg::S_RUN: begin
          if (!busy) begin
            r0.done_res       = 1'b1;
            r0.target_status  = stat_q;
            r0.target_message = msg_q;
            state_d           = sips_pkg::S_IDLE;
          end else if (req) begin
            case (phase)
              sips_pkg::PH_COMMAND: begin
                r0.bus_write       = sips_pkg::BW_DATA;
                r0.bus_write_value = cb_rd;
                if (pos_in) begin
                  pos_d = pos_q + sips_pkg::CPOS_W'(1);
                end
              end
              sips_pkg::PH_DATA_OUT, sips_pkg::PH_DATA_IN: begin
                dir_d            = (phase == sips_pkg::PH_DATA_OUT);
                r0.dma_start     = 1'b1;
                r0.dma_to_device = (phase == sips_pkg::PH_DATA_OUT);
                r0.dma_address   = addr_q;
                r0.dma_count     = ~addr_q[15:0];
                state_d          = sips_pkg::S_DMA;
              end
              sips_pkg::PH_STATUS: begin
                stat_d = item_i.bus_data;
              end
              sips_pkg::PH_MSG_IN: begin
                msg_d = item_i.bus_data;
              end
              default: begin
              end
            endcase
          end
        end
        sips_pkg::S_DMA: begin
          if (item_i.dma_terminal || left) begin
            r0.dma_stop      = 1'b1;
            r0.dma_to_device = dir_q;
            addr_d           = addr_next_seg;
            if (left) begin
              state_d = sips_pkg::S_RUN;
            end else begin
              // Chain the next burst at the following 64KB segment
              r1.dma_start     = 1'b1;
              r1.dma_to_device = dir_q;
              r1.dma_address   = addr_next_seg;
              r1.dma_count     = 16'hFFFF;
              two              = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    r0.last = !two;
    r1.last = 1'b1;
  end

  assign push_o.push = step_i;
  assign push_o.two  = two;
  assign push_o.r0   = r0;
  assign push_o.r1   = r1;

  // Hold control state; advance on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sips_pkg::S_IDLE;
      wlim_q  <= sips_pkg::WAIT_LIMIT_RST;
      poll_q  <= '0;
      pos_q   <= '0;
      addr_q  <= '0;
      tgt_q   <= '0;
      stat_q  <= '0;
      msg_q   <= '0;
      dir_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wlim_q <= cfg_wdata_i;
      end
      if (step_i) begin
        state_q <= state_d;
        poll_q  <= poll_d;
        pos_q   <= pos_d;
        addr_q  <= addr_d;
        tgt_q   <= tgt_d;
        stat_q  <= stat_d;
        msg_q   <= msg_d;
        dir_q   <= dir_d;
      end
    end
  end

  // Command byte store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sips_pkg::CDB_BYTES; i++) begin
        cb_q[i] <= '0;
      end
    end else if (cb_we) begin
      cb_q[item_i.cdb_index[sips_pkg::CDB_AW-1:0]] <= item_i.cdb_byte;
    end
  end

  // A reported end always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && r0.done_res) |=> (state_q == sips_pkg::S_IDLE))
    else $error("sequencer not idle after done");

  // Two results come only from selection or a chained burst
  a_two_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && two) |-> (state_q == sips_pkg::S_FREE || state_q == sips_pkg::S_DMA))
    else $error("two results from unexpected state");

endmodule
`default_nettype wire

@@ design/sips_rqueue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sips_rqueue
// Small result queue: takes one or two results per cycle while it has room, hands out one.
// ----------------------------------------------------------------------------
module sips_rqueue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sips_pkg::push_t push_i,
  input  wire logic            pop_i,
  output logic                 room_o,
  output logic                 valid_o,
  output sips_pkg::res_t       head_o
);

  sips_pkg::res_t               mem_q [sips_pkg::RQ_DEPTH];
  logic [sips_pkg::RQ_AW-1:0]   wr_q, wr_d;
  logic [sips_pkg::RQ_AW-1:0]   rd_q, rd_d;
  logic [sips_pkg::RQ_CW-1:0]   cnt_q, cnt_d;
  logic [sips_pkg::RQ_CW-1:0]   n_push;
  logic                         pop;

  assign pop     = pop_i && valid_o;
  assign n_push  = !push_i.push ? '0 :
                   (push_i.two ? sips_pkg::RQ_CW'(2) : sips_pkg::RQ_CW'(1));
  assign wr_d    = wr_q + n_push[sips_pkg::RQ_AW-1:0];
  assign rd_d    = rd_q + sips_pkg::RQ_AW'(pop);
  assign cnt_d   = cnt_q + n_push - sips_pkg::RQ_CW'(pop);
  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= sips_pkg::RQ_CW'(sips_pkg::RQ_DEPTH - 2);
  assign head_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Write the incoming results
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.r0;
      if (push_i.two) begin
        mem_q[wr_q + sips_pkg::RQ_AW'(1)] <= push_i.r1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> (cnt_q <= sips_pkg::RQ_CW'(sips_pkg::RQ_DEPTH - 2)))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sips_pkg::RQ_CW'(sips_pkg::RQ_DEPTH))
    else $error("result queue count out of range");

endmodule
`default_nettype wire

@@ design/scsi_initiator_phase_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsi_initiator_phase_sequencer
// SCSI initiator bus phase sequencer: selection, command, DMA bursts and
// status/message capture, one bus sample per transaction.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     action .. dma_terminal
//   out      output     out_valid_o / out_stall_i   bus_write .. last
//   cfg      input      cfg_we_i                    cfg_wdata_i (wait limit)
//
// An item is registered on accept and processed once the result queue has
// room; its results are registered into the queue. One item per cycle while
// in_stall_o is low; items yielding two results drain at one result a cycle,
// when out_stall_i is low, through a four-entry queue that sets the rate.
// in_stall_o rises only while the queue lacks room for two results.
// Reset clears all sequencer state; the wait limit returns to 3000.
// ----------------------------------------------------------------------------
module scsi_initiator_phase_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [2:0]  target_id_i,
  input  wire logic [31:0] buffer_address_i,
  input  wire logic [3:0]  cdb_index_i,
  input  wire logic [7:0]  cdb_byte_i,
  input  wire logic [7:0]  bus_status_i,
  input  wire logic [7:0]  bus_data_i,
  input  wire logic        dma_terminal_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       bus_write_o,
  output logic [7:0]       bus_write_value_o,
  output logic             dma_start_o,
  output logic             dma_to_device_o,
  output logic [31:0]      dma_address_o,
  output logic [15:0]      dma_count_o,
  output logic             dma_stop_o,
  output logic             done_res_o,
  output logic             timed_out_o,
  output logic [7:0]       target_status_o,
  output logic [7:0]       target_message_o,
  output logic             last_o
);

  sips_pkg::item_t item_q;
  logic            item_vld_q, item_vld_d;
  logic            room;
  logic            step;
  logic            in_acc;
  sips_pkg::push_t push;
  sips_pkg::res_t  head;

  assign step       = item_vld_q && room;
  assign in_stall_o = item_vld_q && !room;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign item_vld_d = in_acc || (item_vld_q && !step);

  // Hold the input transaction until the step takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.action         <= action_i;
      item_q.target_id      <= target_id_i;
      item_q.buffer_address <= buffer_address_i;
      item_q.cdb_index      <= cdb_index_i;
      item_q.cdb_byte       <= cdb_byte_i;
      item_q.bus_status     <= bus_status_i;
      item_q.bus_data       <= bus_data_i;
      item_q.dma_terminal   <= dma_terminal_i;
    end
  end

  sips_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item_q),
    .push_o      (push)
  );

  sips_rqueue u_rqueue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // Drive the result transaction from the queue head
  assign bus_write_o       = head.bus_write;
  assign bus_write_value_o = head.bus_write_value;
  assign dma_start_o       = head.dma_start;
  assign dma_to_device_o   = head.dma_to_device;
  assign dma_address_o     = head.dma_address;
  assign dma_count_o       = head.dma_count;
  assign dma_stop_o        = head.dma_stop;
  assign done_res_o        = head.done_res;
  assign timed_out_o       = head.timed_out;
  assign target_status_o   = head.target_status;
  assign target_message_o  = head.target_message;
  assign last_o            = head.last;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SCSI initiator phase sequencer. A directed
// table walks the selection, command, DMA, status and message phases and
// the ignored cases. Randomized command runs follow, shaped by the
// predicted sequencer state, under several wait limits. Every result is
// compared field by field against a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module tb_top;

  // Action code outside the defined set, dropped by the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         RUN_ITEMS  = 192;
  localparam int         RUN_PHASES = 6;

  typedef struct packed {
    sips_pkg::item_t it;
    logic            typed;
    sips_pkg::res_t  want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [2:0]  target_id_i = '0;
  logic [31:0] buffer_address_i = '0;
  logic [3:0]  cdb_index_i = '0;
  logic [7:0]  cdb_byte_i = '0;
  logic [7:0]  bus_status_i = '0;
  logic [7:0]  bus_data_i = '0;
  logic        dma_terminal_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  bus_write_o;
  logic [7:0]  bus_write_value_o;
  logic        dma_start_o;
  logic        dma_to_device_o;
  logic [31:0] dma_address_o;
  logic [15:0] dma_count_o;
  logic        dma_stop_o;
  logic        done_res_o;
  logic        timed_out_o;
  logic [7:0]  target_status_o;
  logic [7:0]  target_message_o;
  logic        last_o;

  // Sequencer model state
  sips_pkg::state_e seq_st = sips_pkg::S_IDLE;
  logic [15:0] polls = '0;
  logic [7:0]  cdb_mem [sips_pkg::CDB_BYTES];
  logic [3:0]  cmd_pos = '0;
  logic [31:0] xfer_addr = '0;
  logic [2:0]  sel_tgt = '0;
  logic [7:0]  stat_byte = '0;
  logic [7:0]  msg_byte = '0;
  logic        to_dev = 1'b0;
  logic [15:0] wait_lim = sips_pkg::WAIT_LIMIT_RST;

  sips_pkg::res_t step_res [$];
  sips_pkg::res_t bus_results_q [$];
  row_t           script [$];
  sips_pkg::res_t got;
  sips_pkg::res_t want;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;

  scsi_initiator_phase_sequencer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .target_id_i       (target_id_i),
    .buffer_address_i  (buffer_address_i),
    .cdb_index_i       (cdb_index_i),
    .cdb_byte_i        (cdb_byte_i),
    .bus_status_i      (bus_status_i),
    .bus_data_i        (bus_data_i),
    .dma_terminal_i    (dma_terminal_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .bus_write_o       (bus_write_o),
    .bus_write_value_o (bus_write_value_o),
    .dma_start_o       (dma_start_o),
    .dma_to_device_o   (dma_to_device_o),
    .dma_address_o     (dma_address_o),
    .dma_count_o       (dma_count_o),
    .dma_stop_o        (dma_stop_o),
    .done_res_o        (done_res_o),
    .timed_out_o       (timed_out_o),
    .target_status_o   (target_status_o),
    .target_message_o  (target_message_o),
    .last_o            (last_o)
  );

  always #5ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------
  function automatic void put_write(logic [1:0] port, logic [7:0] value);
    sips_pkg::res_t r;
    r = '0;
    r.bus_write = port;
    r.bus_write_value = value;
    step_res.push_back(r);
  endfunction

  function automatic void put_burst();
    sips_pkg::res_t r;
    r = '0;
    r.dma_start = 1'b1;
    r.dma_to_device = to_dev;
    r.dma_address = xfer_addr;
    r.dma_count = 16'hFFFF - xfer_addr[15:0];
    step_res.push_back(r);
  endfunction

  function automatic void put_finish(logic tmo);
    sips_pkg::res_t r;
    r = '0;
    r.done_res = 1'b1;
    r.timed_out = tmo;
    r.target_status = tmo ? 8'h00 : stat_byte;
    r.target_message = tmo ? 8'h00 : msg_byte;
    step_res.push_back(r);
    seq_st = sips_pkg::S_IDLE;
  endfunction

  // Count one failing wait sample; true once the wait limit is reached
  function automatic bit wait_expired();
    logic [16:0] c;
    c = {1'b0, polls} + 17'd1;
    if (c >= {1'b0, wait_lim}) return 1'b1;
    polls = c[15:0];
    return 1'b0;
  endfunction

  // Apply one transaction; fill step_res, return true if the block drops it
  function automatic bit advance_sequencer(sips_pkg::item_t it);
    logic [7:0]     st;
    logic           busy;
    logic           away;
    bit             ignored;
    sips_pkg::res_t r;
    st = it.bus_status;
    busy = st[3];
    ignored = 1'b0;
    step_res.delete();
    case (it.action)
      sips_pkg::ACT_START: begin
        if (seq_st == sips_pkg::S_IDLE) begin
          sel_tgt = it.target_id;
          xfer_addr = it.buffer_address;
          polls = '0;
          cmd_pos = '0;
          stat_byte = '0;
          msg_byte = '0;
          to_dev = 1'b0;
          seq_st = sips_pkg::S_FREE;
        end else begin
          ignored = 1'b1;
        end
      end
      sips_pkg::ACT_LOAD: begin
        if (it.cdb_index < sips_pkg::CDB_BYTES) cdb_mem[it.cdb_index] = it.cdb_byte;
        else ignored = 1'b1;
      end
      sips_pkg::ACT_SAMPLE: begin
        case (seq_st)
          sips_pkg::S_FREE: begin
            if (!busy) begin
              put_write(sips_pkg::BW_DATA, sips_pkg::SEL_OWN_ID | (8'd1 << sel_tgt));
              put_write(sips_pkg::BW_CMD, sips_pkg::CMD_SELECT);
              polls = '0;
              seq_st = sips_pkg::S_BUSY;
            end else if (wait_expired()) begin
              put_finish(1'b1);
            end
          end
          sips_pkg::S_BUSY: begin
            if (busy) begin
              put_write(sips_pkg::BW_CMD, sips_pkg::CMD_SEQUENCE);
              seq_st = sips_pkg::S_RUN;
            end else if (wait_expired()) begin
              put_finish(1'b1);
            end
          end
          sips_pkg::S_RUN: begin
            if (!busy) begin
              put_finish(1'b0);
            end else if (st[7]) begin
              case (st[6:4])
                sips_pkg::PH_COMMAND: begin
                  put_write(sips_pkg::BW_DATA,
                            (cmd_pos < sips_pkg::CDB_BYTES) ? cdb_mem[cmd_pos] : 8'h00);
                  if (cmd_pos < sips_pkg::CDB_BYTES) cmd_pos = cmd_pos + 4'd1;
                end
                sips_pkg::PH_DATA_IN, sips_pkg::PH_DATA_OUT: begin
                  to_dev = (st[6:4] == sips_pkg::PH_DATA_OUT);
                  put_burst();
                  seq_st = sips_pkg::S_DMA;
                end
                sips_pkg::PH_STATUS: stat_byte = it.bus_data;
                sips_pkg::PH_MSG_IN: msg_byte = it.bus_data;
                default: ;
              endcase
            end
          end
          sips_pkg::S_DMA: begin
            // Leaving means BUSY gone or the phase out of the data group
            away = !busy || (st[5:4] != 2'b00);
            if (it.dma_terminal || away) begin
              r = '0;
              r.dma_stop = 1'b1;
              r.dma_to_device = to_dev;
              step_res.push_back(r);
              xfer_addr = {xfer_addr[31:16] + 16'd1, 16'h0000};
              if (away) seq_st = sips_pkg::S_RUN;
              else put_burst();
            end
          end
          default: ignored = 1'b1;
        endcase
      end
      default: ignored = 1'b1;
    endcase
    // Every transaction yields at least one result; mark the final one
    if (step_res.size() == 0) begin
      r = '0;
      step_res.push_back(r);
    end
    r = step_res.pop_back();
    r.last = 1'b1;
    step_res.push_back(r);
    return ignored;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic row_t mk(logic [1:0] act, logic [2:0] tgt, logic [31:0] addr,
                              logic [3:0] idx, logic [7:0] byt, logic [7:0] st,
                              logic [7:0] dat, logic term, logic typed,
                              logic done, logic tmo);
    row_t row;
    row = '0;
    row.it.action = act;
    row.it.target_id = tgt;
    row.it.buffer_address = addr;
    row.it.cdb_index = idx;
    row.it.cdb_byte = byt;
    row.it.bus_status = st;
    row.it.bus_data = dat;
    row.it.dma_terminal = term;
    row.typed = typed;
    row.want.done_res = done;
    row.want.timed_out = tmo;
    row.want.last = 1'b1;
    return row;
  endfunction

  // Draw a transaction that fits the predicted state, with some noise
  function automatic sips_pkg::item_t next_item();
    sips_pkg::item_t it;
    int              r;
    it.action = sips_pkg::ACT_SAMPLE;
    it.target_id = 3'($urandom);
    it.buffer_address = $urandom;
    it.cdb_index = 4'($urandom);
    it.cdb_byte = 8'($urandom);
    it.bus_status = 8'($urandom);
    it.bus_data = 8'($urandom);
    it.dma_terminal = 1'($urandom);
    if ($urandom_range(0, 99) < 6) begin
      it.action = 2'($urandom_range(0, 3));
      return it;
    end
    r = $urandom_range(0, 99);
    case (seq_st)
      sips_pkg::S_IDLE: begin
        if (r < 40) begin
          it.action = sips_pkg::ACT_LOAD;
          it.cdb_index = (r < 5) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
        end else if (r >= 45) begin
          it.action = sips_pkg::ACT_START;
          // Bias bursts toward segment ends and the top of memory
          if ($urandom_range(0, 2) == 0) it.buffer_address[15:4] = 12'hFFF;
          if ($urandom_range(0, 9) == 0) it.buffer_address[31:16] = 16'hFFFF;
        end
      end
      sips_pkg::S_FREE: it.bus_status[3] = (r < 35);
      sips_pkg::S_BUSY: it.bus_status[3] = (r < 70);
      sips_pkg::S_RUN: begin
        it.bus_status[3] = (r >= 3);
        it.bus_status[7] = 1'b1;
        if (r < 40) it.bus_status[6:4] = sips_pkg::PH_COMMAND;
        else if (r < 55) it.bus_status[6:4] = sips_pkg::PH_DATA_IN;
        else if (r < 65) it.bus_status[6:4] = sips_pkg::PH_DATA_OUT;
        else if (r < 72) it.bus_status[6:4] = sips_pkg::PH_STATUS;
        else if (r < 79) it.bus_status[6:4] = sips_pkg::PH_MSG_IN;
        else if (r >= 87) it.bus_status[7] = 1'b0;
      end
      sips_pkg::S_DMA: begin
        if (r < 25) begin
          it.dma_terminal = 1'b1;
          it.bus_status[5:3] = 3'b001;
        end else if (r >= 45) begin
          it.dma_terminal = 1'b0;
          it.bus_status[5:3] = 3'b001;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // Hold one transaction until accepted, then record its expected results
  task automatic send_item(input sips_pkg::item_t it, input logic typed,
                           input sips_pkg::res_t fixed, output bit ignored);
    in_valid_i <= 1'b1;
    action_i <= it.action;
    target_id_i <= it.target_id;
    buffer_address_i <= it.buffer_address;
    cdb_index_i <= it.cdb_index;
    cdb_byte_i <= it.cdb_byte;
    bus_status_i <= it.bus_status;
    bus_data_i <= it.bus_data;
    dma_terminal_i <= it.dma_terminal;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    ignored = advance_sequencer(it);
    if (typed) bus_results_q.push_back(fixed);
    else foreach (step_res[k]) bus_results_q.push_back(step_res[k]);
  endtask

  task automatic maybe_gap();
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bus_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_wait_limit(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wait_lim = value;
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] dut_val, logic [31:0] exp_val);
    if (dut_val !== exp_val)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, dut_val, exp_val));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {bus_write_o, bus_write_value_o, dma_start_o, dma_to_device_o,
             dma_address_o, dma_count_o, dma_stop_o, done_res_o, timed_out_o,
             target_status_o, target_message_o, last_o};
      if (bus_results_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = bus_results_q.pop_front();
        check_field("bus_write", 32'(got.bus_write), 32'(want.bus_write));
        check_field("bus_write_value", 32'(got.bus_write_value),
                    32'(want.bus_write_value));
        check_field("dma_start", 32'(got.dma_start), 32'(want.dma_start));
        check_field("dma_to_device", 32'(got.dma_to_device), 32'(want.dma_to_device));
        check_field("dma_address", got.dma_address, want.dma_address);
        check_field("dma_count", 32'(got.dma_count), 32'(want.dma_count));
        check_field("dma_stop", 32'(got.dma_stop), 32'(want.dma_stop));
        check_field("done_res", 32'(got.done_res), 32'(want.done_res));
        check_field("timed_out", 32'(got.timed_out), 32'(want.timed_out));
        check_field("target_status", 32'(got.target_status), 32'(want.target_status));
        check_field("target_message", 32'(got.target_message),
                    32'(want.target_message));
        check_field("last", 32'(got.last), 32'(want.last));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sips_pkg::item_t it;
    bit              ignored;
    int              counted;
    logic [15:0]     limit;
    foreach (cdb_mem[k]) cdb_mem[k] = '0;

    // Directed walk: ignored cases, timeout, then one full command run
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd7, '1, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                        1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_LOAD, 3'd0, '0, 4'd0, 8'hFF, 8'h00, 8'h00, 1'b0,
                        1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_LOAD, 3'd0, '0, 4'd9, 8'h5A, 8'h00, 8'h00, 1'b0,
                        1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_LOAD, 3'd0, '0, 4'hF, 8'h00, 8'h00, 8'h00, 1'b0,
                        1'b1, 1'b0, 1'b0));
    script.push_back(mk(ACT_UNUSED, 3'd7, '1, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                        1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_START, 3'd7, 32'hFFFF_FFFF, 4'd0, 8'h00, 8'h00,
                        8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_START, 3'd0, 32'h0, 4'd0, 8'h00, 8'h00, 8'h00,
                        1'b0, 1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'h08, 8'h00, 1'b0,
                        1'b1, 1'b1, 1'b1));
    script.push_back(mk(sips_pkg::ACT_START, 3'd0, 32'h0001_FFF0, 4'd0, 8'h00, 8'h00,
                        8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'h00, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'h08, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    // Run the command phase one byte past the end of the block
    for (int k = 0; k <= sips_pkg::CDB_BYTES; k++)
      script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'h98, 8'h00,
                          1'b0, 1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hC8, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hC8, 8'h00, 1'b1,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hD8, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hD8, 8'hFF, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'h88, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hF0, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hF8, 8'h3C, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'hA8, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));
    script.push_back(mk(sips_pkg::ACT_SAMPLE, 3'd0, '0, 4'd0, 8'h00, 8'h00, 8'h00, 1'b0,
                        1'b0, 1'b0, 1'b0));

    // Hold reset, then release it
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_wait_limit(16'd1);
    gap_pct = 20;
    stall_pct = 20;
    foreach (script[i]) begin
      maybe_gap();
      send_item(script[i].it, script[i].typed, script[i].want, ignored);
    end

    // Random runs, one wait limit each, last run without idling
    for (int p = 0; p < RUN_PHASES; p++) begin
      drain();
      case (p)
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2: limit = 16'($urandom_range(2, 6));
        3: limit = 16'd1;
        4: limit = 16'($urandom_range(1, 65535));
        default: limit = sips_pkg::WAIT_LIMIT_RST;
      endcase
      set_wait_limit(limit);
      gap_pct = (p == RUN_PHASES - 1) ? 0 : pick_pct();
      stall_pct = (p == RUN_PHASES - 1) ? 0 : pick_pct();
      counted = 0;
      while (counted < RUN_ITEMS) begin
        maybe_gap();
        it = next_item();
        send_item(it, 1'b0, '0, ignored);
        if (!ignored) counted++;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Bound the run well above the slowest legal completion
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", bus_results_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
